[rtl/sitoa_pkg.sv]
// Shared types and constants for the signed integer to decimal text converter.
package sitoa_pkg;

    // Widths of the value and of the text characters
    localparam int VALUE_W  = 32;
    localparam int CHAR_W   = 7;
    localparam int DIGIT_W  = 4;
    localparam int MAX_DIGITS = 10;
    localparam int NDIG_W   = 4;
    localparam int QUOT_W   = 29;

    // Reciprocal of ten: floor(x / 10) == (x * RECIP_TEN) >> RECIP_SHIFT for any 32-bit x
    localparam logic [VALUE_W-1:0] RECIP_TEN   = 32'hCCCC_CCCD;
    localparam int                 RECIP_SHIFT = 35;

    // ASCII codes
    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 7'h2D;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;        // take a new value, form its magnitude
        logic mul;         // register the reciprocal product
        logic dig;         // peel off one digit
        logic emit_sign;   // load '-' into the output register
        logic emit_digit;  // load the next digit into the output register
    } sitoa_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic q_zero;       // quotient of this step is zero
        logic digits_full;  // this step writes the last digit slot
        logic negative;     // the value held is negative
        logic out_free;     // output register can take an item this cycle
        logic last_digit;   // the digit about to be emitted is the final one
    } sitoa_stat_t;

endpackage

[rtl/sitoa_dpath.sv]
// Datapath: magnitude, divide-by-ten step, digit store and output register.
module sitoa_dpath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [sitoa_pkg::VALUE_W-1:0] value,
    input  sitoa_pkg::sitoa_cmd_t         cmd,
    output sitoa_pkg::sitoa_stat_t        stat,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [sitoa_pkg::CHAR_W-1:0]  out_char,
    output logic                          out_last
);
    import sitoa_pkg::*;

    logic [VALUE_W-1:0]   cur_reg;
    logic [QUOT_W-1:0]    q_reg;
    logic [NDIG_W-1:0]    ndig_reg;
    logic                 neg_reg;
    logic [DIGIT_W-1:0]   dig_mem [MAX_DIGITS];

    logic                 out_valid_reg;
    logic [CHAR_W-1:0]    out_char_reg;
    logic                 out_last_reg;

    logic [VALUE_W-1:0]   mag;
    logic [2*VALUE_W-1:0] prod;
    logic [VALUE_W-1:0]   q_ext;
    logic [VALUE_W-1:0]   tens;
    logic [VALUE_W-1:0]   rem;
    logic [NDIG_W-1:0]    rd_idx;

    // Two's complement magnitude; the most negative value maps to 2^31 exactly
    assign mag = value[VALUE_W-1] ? (~value + VALUE_W'(1)) : value;

    // Quotient by reciprocal multiplication, remainder by shift-and-add
    assign prod   = {{VALUE_W{1'b0}}, cur_reg} * {{VALUE_W{1'b0}}, RECIP_TEN};
    assign q_ext  = {{(VALUE_W-QUOT_W){1'b0}}, q_reg};
    assign tens   = (q_ext << 3) + (q_ext << 1);
    assign rem    = cur_reg - tens;
    assign rd_idx = ndig_reg - NDIG_W'(1);

    // Conversion registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cur_reg  <= mag;
            neg_reg  <= value[VALUE_W-1];
            ndig_reg <= '0;
        end else if (cmd.mul) begin
            q_reg <= prod[2*VALUE_W-1:RECIP_SHIFT];
        end else if (cmd.dig) begin
            dig_mem[ndig_reg] <= rem[DIGIT_W-1:0];
            cur_reg           <= q_ext;
            ndig_reg          <= ndig_reg + NDIG_W'(1);
        end else if (cmd.emit_digit) begin
            ndig_reg <= rd_idx;
        end
    end

    // Output register: holds one character until it is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit_sign || cmd.emit_digit) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_sign) begin
            out_char_reg <= ASCII_MINUS;
            out_last_reg <= 1'b0;
        end else if (cmd.emit_digit) begin
            out_char_reg <= ASCII_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, dig_mem[rd_idx]};
            out_last_reg <= (ndig_reg == NDIG_W'(1));
        end
    end

    // Status back to the controller
    always_comb begin
        stat.q_zero      = (q_reg == '0);
        stat.digits_full = (ndig_reg == NDIG_W'(MAX_DIGITS - 1));
        stat.negative    = neg_reg;
        stat.out_free    = !out_valid_reg || out_ready;
        stat.last_digit  = (ndig_reg == NDIG_W'(1));
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign out_last  = out_last_reg;

endmodule

[rtl/sitoa_ctrl.sv]
// Controller: sequences load, digit extraction and character emission.
module sitoa_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  sitoa_pkg::sitoa_stat_t stat,
    output sitoa_pkg::sitoa_cmd_t  cmd
);
    import sitoa_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_DIG  = 3'd2;
    localparam logic [2:0] ST_SIGN = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_DIG;
            end
            ST_DIG: begin
                cmd.dig = 1'b1;
                if (stat.q_zero || stat.digits_full) begin
                    state_next = stat.negative ? ST_SIGN : ST_EMIT;
                end else begin
                    state_next = ST_MUL;
                end
            end
            ST_SIGN: begin
                if (stat.out_free) begin
                    cmd.emit_sign = 1'b1;
                    state_next    = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit_digit = 1'b1;
                    if (stat.last_digit) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/signed_int_to_decimal_ascii.sv]
// Top level of the signed 32-bit integer to decimal ASCII text converter.
//
// Each accepted item carries one signed 32-bit integer; the block answers with
// its decimal text, one ASCII character per result item, '-' first for a
// negative value, digits most significant first, no leading zeros, and tlast
// on the final character. One value is converted at a time. Digits are found
// least significant first by a divide-by-ten step (reciprocal multiply, then a
// shift-and-add remainder): a multiply state registers the product and a digit
// state stores the digit, once per digit. The 1 to 11 characters are then
// emitted at one per cycle while the output side keeps tready high. The next
// value is taken once the final character has been loaded into the output
// register.
module signed_int_to_decimal_ascii (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value (signed)
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [6:0] character, [7] zero pad
    output logic        m_tlast    // last
);
    import sitoa_pkg::*;

    sitoa_cmd_t        cmd;
    sitoa_stat_t       stat;
    logic [CHAR_W-1:0] out_char;

    sitoa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sitoa_dpath u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .value     (s_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_char  (out_char),
        .out_last  (m_tlast)
    );

    assign m_tdata = {1'b0, out_char};

endmodule
